/* hdl/sbc_pkg.sv */
// shared constants, tables and types of the syn/syn-ack bloom classifier
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

  // filter geometry
  localparam int unsigned TABLE_DEPTH = 262144;
  localparam int unsigned COUNTER_W   = 8;
  localparam int unsigned HASH_COUNT  = 8;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned HASH_IDX_W  = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

  localparam logic [COUNTER_W-1:0] CNT_MAX = {COUNTER_W{1'b1}};

  // hashing arithmetic
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned NUM_PRIMES  = 8;
  localparam int unsigned PRIME_IDX_W = $clog2(NUM_PRIMES);
  localparam int unsigned PRIME_W     = 18;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned HASH_SHIFT  = 14;
  localparam int unsigned HASH_HI_W   = KEY_W - HASH_SHIFT;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned QUOT_W      = 15;
  localparam int unsigned MUL_W       = RECIP_SHIFT + QUOT_W;
  localparam int unsigned REM_W       = PRIME_W + 2;

  localparam logic [63:0] RECIP_NUM = 64'd1 << (HASH_SHIFT + RECIP_SHIFT);

  typedef logic [PRIME_W-1:0] prime_t;
  typedef logic [RECIP_W-1:0] recip_t;

  localparam prime_t HASH_PRIME [NUM_PRIMES] = '{
    PRIME_W'(224171), PRIME_W'(214237), PRIME_W'(205633), PRIME_W'(167917),
    PRIME_W'(174829), PRIME_W'(193139), PRIME_W'(187909), PRIME_W'(197779)
  };

  // floor(2^36 / prime): quotient estimate never exceeds the true quotient
  localparam recip_t HASH_RECIP [NUM_PRIMES] = '{
    RECIP_W'(RECIP_NUM / 64'd224171), RECIP_W'(RECIP_NUM / 64'd214237),
    RECIP_W'(RECIP_NUM / 64'd205633), RECIP_W'(RECIP_NUM / 64'd167917),
    RECIP_W'(RECIP_NUM / 64'd174829), RECIP_W'(RECIP_NUM / 64'd193139),
    RECIP_W'(RECIP_NUM / 64'd187909), RECIP_W'(RECIP_NUM / 64'd197779)
  };

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HKEY,
    ST_HQUOT,
    ST_HPROD,
    ST_HREM,
    ST_CHK_RD,
    ST_CHK_END,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CLASS_SYN       = 2'd0,
    CLASS_MATCHED   = 2'd1,
    CLASS_UNMATCHED = 2'd2,
    CLASS_OTHER     = 2'd3
  } class_e;

endpackage

`default_nettype wire

/* hdl/sbc_ram.sv */
// simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module sbc_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 8,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/syn_ack_counting_bloom_classifier_top.sv */
// syn/syn-ack classifier built on a counting bloom filter in one shared ram
// busy rises at the accepting edge and stays high until the packet is done;
//   result strobe comes in the cycle busy falls, start taken there too
// hashing: key multiply; quotient, product, remainder per prime; one 32x32 multiplier
// filter work: syn-ack lookups, then a read and a write state per update on the one ram
// reset clears control at once, then a pass zeroes the whole filter with busy high
// results leave as a one-cycle strobe; the receiver cannot stall them
`timescale 1ns / 1ps
`default_nettype none

module syn_ack_counting_bloom_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] seq_number_i,
  input  wire logic [31:0] ack_number_i,
  input  wire logic        syn_flag_i,
  input  wire logic        ack_flag_i,
  input  wire logic        end_flag_i,
  output logic             valid_o,
  output logic [1:0]       packet_class_o,
  output logic             end_out_o,
  output logic [31:0]      syn_total_o,
  output logic [31:0]      matched_total_o,
  output logic [31:0]      unmatched_total_o
);

  import sbc_pkg::*;

  // sequencer
  state_e state_q, state_d;

  // clearing pass address after reset
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  // hash / filter step index, shared by hashing, lookup and update loops
  logic [HASH_IDX_W-1:0] idx_q, idx_d;

  // per-packet working registers
  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] h_q, h_d;
  logic [MUL_W-1:0] mul_q, mul_d;
  class_e           cls_q, cls_d;
  logic             end_q, end_d;
  logic             zero_seen_q, zero_seen_d;

  // hash positions, one per prime
  logic [ADDR_W-1:0] pos_q [HASH_COUNT];
  logic              pos_we;
  logic [ADDR_W-1:0] pos_wdata;

  // running totals and result strobe
  logic [31:0] syn_cnt_q, syn_cnt_d;
  logic [31:0] match_cnt_q, match_cnt_d;
  logic [31:0] unmatch_cnt_q, unmatch_cnt_d;
  logic        valid_q, valid_d;

  // shared multiplier
  logic [KEY_W-1:0] mul_a, mul_b;
  logic [63:0]      mul_p;

  // filter ram ports
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [COUNTER_W-1:0] ram_wdata, ram_rdata;

  // misc decode
  logic                   idx_last;
  logic                   clr_last;
  logic [PRIME_IDX_W-1:0] pidx;
  logic [ADDR_W-1:0]      cur_pos;
  logic                   rd_zero;
  logic                   any_zero;
  logic [KEY_W-1:0]       rem_full;
  logic [REM_W-1:0]       rem_raw, rem_fix, p1, p2;
  logic [COUNTER_W-1:0]   upd_val;

  assign idx_last = (idx_q == HASH_IDX_W'(HASH_COUNT - 1));
  assign clr_last = (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1));
  assign pidx     = PRIME_IDX_W'(idx_q);
  assign cur_pos  = pos_q[idx_q];
  assign rd_zero  = (ram_rdata == '0);
  assign any_zero = zero_seen_q | rd_zero;

  // one multiplier serves the key product and both halves of each reduction
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // h mod p: remainder from the estimated quotient lies below 3p, fix with two compares
  assign rem_full = h_q - mul_q[KEY_W-1:0];
  assign rem_raw  = rem_full[REM_W-1:0];
  assign p1       = REM_W'(HASH_PRIME[pidx]);
  assign p2       = REM_W'({HASH_PRIME[pidx], 1'b0});

  always_comb begin
    if (rem_raw >= p2) begin
      rem_fix = rem_raw - p2;
    end else if (rem_raw >= p1) begin
      rem_fix = rem_raw - p1;
    end else begin
      rem_fix = rem_raw;
    end
  end

  assign pos_wdata = ADDR_W'(rem_fix);

  // saturating increment for a syn, decrement floored at zero for a matched reply
  always_comb begin
    if (cls_q == CLASS_SYN) begin
      upd_val = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
    end else begin
      upd_val = rd_zero ? ram_rdata : ram_rdata - 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = syn_flag_i ? ST_HKEY : ST_DONE;
      end
      ST_HKEY:  state_d = ST_HQUOT;
      ST_HQUOT: state_d = ST_HPROD;
      ST_HPROD: state_d = ST_HREM;
      ST_HREM: begin
        if (!idx_last) begin
          state_d = ST_HQUOT;
        end else if (cls_q == CLASS_SYN) begin
          state_d = ST_UPD_RD;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        if (idx_last) state_d = ST_CHK_END;
      end
      ST_CHK_END: state_d = any_zero ? ST_DONE : ST_UPD_RD;
      ST_UPD_RD:  state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        if (idx_last) state_d = ST_DONE;
        else          state_d = ST_UPD_RD;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: ram ports, multiplier operands, handshake
  always_comb begin
    busy      = (state_q != ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = cur_pos;
    ram_wdata = upd_val;
    ram_re    = 1'b0;
    ram_raddr = cur_pos;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      ST_HKEY: begin
        // key * (key + 3), low word kept
        mul_a = key_q;
        mul_b = key_q + KEY_W'(3);
      end
      ST_HQUOT: begin
        // quotient estimate from the top bits of h
        mul_a = KEY_W'(h_q[KEY_W-1:HASH_SHIFT]);
        mul_b = KEY_W'(HASH_RECIP[pidx]);
      end
      ST_HPROD: begin
        mul_a = KEY_W'(mul_q[RECIP_SHIFT +: QUOT_W]);
        mul_b = KEY_W'(HASH_PRIME[pidx]);
      end
      ST_CHK_RD, ST_UPD_RD: begin
        ram_re = 1'b1;
      end
      ST_UPD_WR: begin
        ram_we = 1'b1;
      end
      ST_IDLE, ST_HREM, ST_CHK_END, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_addr_d    = clr_addr_q;
    idx_d         = idx_q;
    key_d         = key_q;
    h_d           = h_q;
    mul_d         = mul_q;
    cls_d         = cls_q;
    end_d         = end_q;
    zero_seen_d   = zero_seen_q;
    pos_we        = 1'b0;
    syn_cnt_d     = syn_cnt_q;
    match_cnt_d   = match_cnt_q;
    unmatch_cnt_d = unmatch_cnt_q;
    valid_d       = (state_q == ST_DONE);
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          // a syn-ack looks up the sequence number it acknowledges
          key_d       = (syn_flag_i && ack_flag_i) ? ack_number_i - 32'd1 : seq_number_i;
          end_d       = end_flag_i;
          zero_seen_d = 1'b0;
          idx_d       = '0;
          if (!syn_flag_i)      cls_d = CLASS_OTHER;
          else if (ack_flag_i)  cls_d = CLASS_MATCHED;
          else                  cls_d = CLASS_SYN;
        end
      end
      ST_HKEY: begin
        h_d = mul_p[KEY_W-1:0];
      end
      ST_HQUOT, ST_HPROD: begin
        mul_d = mul_p[MUL_W-1:0];
      end
      ST_HREM: begin
        pos_we = 1'b1;
        idx_d  = idx_last ? '0 : idx_q + 1'b1;
      end
      ST_CHK_RD: begin
        // read data comes back in the cycle after its address
        if (idx_q != '0) zero_seen_d = zero_seen_q | rd_zero;
        idx_d = idx_last ? '0 : idx_q + 1'b1;
      end
      ST_CHK_END: begin
        zero_seen_d = any_zero;
        if (any_zero) cls_d = CLASS_UNMATCHED;
      end
      ST_UPD_WR: begin
        idx_d = idx_last ? '0 : idx_q + 1'b1;
      end
      ST_DONE: begin
        unique case (cls_q)
          CLASS_SYN:       syn_cnt_d     = syn_cnt_q + 32'd1;
          CLASS_MATCHED:   match_cnt_d   = match_cnt_q + 32'd1;
          CLASS_UNMATCHED: unmatch_cnt_d = unmatch_cnt_q + 32'd1;
          CLASS_OTHER: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      idx_q         <= '0;
      valid_q       <= 1'b0;
      syn_cnt_q     <= '0;
      match_cnt_q   <= '0;
      unmatch_cnt_q <= '0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      idx_q         <= idx_d;
      valid_q       <= valid_d;
      syn_cnt_q     <= syn_cnt_d;
      match_cnt_q   <= match_cnt_d;
      unmatch_cnt_q <= unmatch_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    h_q         <= h_d;
    mul_q       <= mul_d;
    cls_q       <= cls_d;
    end_q       <= end_d;
    zero_seen_q <= zero_seen_d;
    if (pos_we) begin
      pos_q[idx_q] <= pos_wdata;
    end
  end

  // counting filter storage
  sbc_ram #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (COUNTER_W)
  ) u_filter (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result transfer
  assign valid_o           = valid_q;
  assign packet_class_o    = cls_q;
  assign end_out_o         = end_q;
  assign syn_total_o       = syn_cnt_q;
  assign matched_total_o   = match_cnt_q;
  assign unmatched_total_o = unmatch_cnt_q;

  // checks
  a_strobe_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_DONE))
    else $error("result strobe without a finished packet");

  a_syn_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && packet_class_o == CLASS_SYN) |-> syn_total_o == $past(syn_total_o) + 32'd1)
    else $error("syn total did not advance by one");

  a_other_keeps_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && packet_class_o == CLASS_OTHER) |->
      ($stable(syn_total_o) && $stable(matched_total_o) && $stable(unmatched_total_o)))
    else $error("plain packet changed a total");

  a_match_needs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_RD && cls_q == CLASS_MATCHED) |-> !zero_seen_q)
    else $error("decrement started although a counter was zero");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_WR) |->
      (ram_wdata == ram_rdata || ram_wdata == ram_rdata + 1'b1 ||
       ram_wdata == ram_rdata - 1'b1))
    else $error("filter counter moved by more than one");

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench of the syn/syn-ack counting bloom classifier
`timescale 1ns / 1ps

module tb;
  import sbc_pkg::*;

  // own copy of the filter geometry and hash primes
  localparam int unsigned FILTER_DEPTH = 262144;
  localparam int unsigned N_HASH       = 8;
  localparam logic [7:0]  CTR_TOP      = 8'hFF;
  localparam int unsigned PRIMES [N_HASH] = '{
    224171, 214237, 205633, 167917, 174829, 193139, 187909, 197779
  };

  localparam int unsigned N_ITEMS = 1700;
  // longest quiet stretch is the filter clearing pass after reset
  localparam int unsigned STALL_LIMIT = 800000;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct {
    logic [31:0] seq;
    logic [31:0] ack;
    logic        syn;
    logic        ackf;
    logic        endf;
    int unsigned gap;
    bit          drain;
  } packet_t;

  typedef struct {
    class_e      cls;
    logic        endf;
    logic [31:0] syn_n;
    logic [31:0] match_n;
    logic [31:0] unmatch_n;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] seq_number_i = '0;
  logic [31:0] ack_number_i = '0;
  logic        syn_flag_i = 1'b0;
  logic        ack_flag_i = 1'b0;
  logic        end_flag_i = 1'b0;
  logic        valid_o;
  logic [1:0]  packet_class_o;
  logic        end_out_o;
  logic [31:0] syn_total_o;
  logic [31:0] matched_total_o;
  logic [31:0] unmatched_total_o;

  syn_ack_counting_bloom_classifier_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .seq_number_i      (seq_number_i),
    .ack_number_i      (ack_number_i),
    .syn_flag_i        (syn_flag_i),
    .ack_flag_i        (ack_flag_i),
    .end_flag_i        (end_flag_i),
    .valid_o           (valid_o),
    .packet_class_o    (packet_class_o),
    .end_out_o         (end_out_o),
    .syn_total_o       (syn_total_o),
    .matched_total_o   (matched_total_o),
    .unmatched_total_o (unmatched_total_o)
  );

  // predictor state: mirror of the filter and the three running totals
  bit [7:0]    bloom_ctr [FILTER_DEPTH];
  logic [31:0] syn_seen;
  logic [31:0] matched_seen;
  logic [31:0] unmatched_seen;

  packet_t     packet_q [$];
  verdict_t    verdict_q [$];
  packet_t     next_pkt;
  int unsigned total_items;
  int unsigned taken_items = 0;
  int unsigned gap_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  bit          took = 1'b0;

  // stimulus shaping
  logic [31:0] syn_pool [$];
  bit          no_idle = 1'b0;
  bit          drain_next = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // eight filter positions of one key
  function automatic void bloom_positions(input logic [31:0] key,
                                          output int unsigned pos [N_HASH]);
    logic [31:0] h;
    h = key * (key + 32'd3);
    for (int i = 0; i < N_HASH; i++) begin
      pos[i] = h % PRIMES[i];
      if (pos[i] >= FILTER_DEPTH) pos[i] = pos[i] % FILTER_DEPTH;
    end
  endfunction

  // classify one packet and update the mirrored filter and totals
  function automatic verdict_t classify_packet(input packet_t p);
    int unsigned pos [N_HASH];
    bit          all_set;
    verdict_t    v;
    v.cls = CLASS_OTHER;
    if (p.syn && p.ackf) begin
      bloom_positions(p.ack - 32'd1, pos);
      all_set = 1'b1;
      for (int i = 0; i < N_HASH; i++)
        if (bloom_ctr[pos[i]] == 8'd0) all_set = 1'b0;
      if (all_set) begin
        // collided positions are decremented once per hash, floored at zero
        for (int i = 0; i < N_HASH; i++)
          if (bloom_ctr[pos[i]] != 8'd0) bloom_ctr[pos[i]]--;
        matched_seen++;
        v.cls = CLASS_MATCHED;
      end else begin
        unmatched_seen++;
        v.cls = CLASS_UNMATCHED;
      end
    end else if (p.syn) begin
      bloom_positions(p.seq, pos);
      for (int i = 0; i < N_HASH; i++)
        if (bloom_ctr[pos[i]] != CTR_TOP) bloom_ctr[pos[i]]++;
      syn_seen++;
      v.cls = CLASS_SYN;
    end
    v.endf      = p.endf;
    v.syn_n     = syn_seen;
    v.match_n   = matched_seen;
    v.unmatch_n = unmatched_seen;
    return v;
  endfunction

  task automatic queue_packet(input logic [31:0] seq, input logic [31:0] ack,
                              input logic syn, input logic ackf, input logic endf);
    packet_t p;
    if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
    p.seq   = seq;
    p.ack   = ack;
    p.syn   = syn;
    p.ackf  = ackf;
    p.endf  = endf;
    p.gap   = no_idle ? 0 : $urandom_range(0, 19);
    p.drain = drain_next;
    drain_next = 1'b0;
    packet_q.insert(packet_q.size(), p);
  endtask

  // driver: new values at the falling edge, held until the transfer happens
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || took) begin
        if (packet_q.size() != 0 && gap_count >= packet_q[0].gap &&
            !(packet_q[0].drain && verdict_q.size() != 0)) begin
          next_pkt     = packet_q.pop_front();
          seq_number_i <= next_pkt.seq;
          ack_number_i <= next_pkt.ack;
          syn_flag_i   <= next_pkt.syn;
          ack_flag_i   <= next_pkt.ackf;
          end_flag_i   <= next_pkt.endf;
          start        <= 1'b1;
          gap_count    = 0;
        end else begin
          start <= 1'b0;
          if (packet_q.size() != 0 && gap_count < packet_q[0].gap) gap_count++;
        end
      end
    end
  end

  // monitor: results checked against the oldest prediction, transfers predicted
  always @(posedge clk_i) begin
    verdict_t exp_v;
    packet_t  seen;
    if (rst_ni) begin
      took = 1'b0;
      if (valid_o === 1'b1) begin
        idle_cycles = 0;
        if (verdict_q.size() == 0) begin
          $error("result strobe with no packet outstanding");
          errors++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (packet_class_o !== exp_v.cls) begin
            $error("packet_class: expected %0d, actual %0d", exp_v.cls, packet_class_o);
            errors++;
          end
          if (end_out_o !== exp_v.endf) begin
            $error("end_out: expected %0d, actual %0d", exp_v.endf, end_out_o);
            errors++;
          end
          if (syn_total_o !== exp_v.syn_n) begin
            $error("syn_total: expected %0d, actual %0d", exp_v.syn_n, syn_total_o);
            errors++;
          end
          if (matched_total_o !== exp_v.match_n) begin
            $error("matched_total: expected %0d, actual %0d",
                   exp_v.match_n, matched_total_o);
            errors++;
          end
          if (unmatched_total_o !== exp_v.unmatch_n) begin
            $error("unmatched_total: expected %0d, actual %0d",
                   exp_v.unmatch_n, unmatched_total_o);
            errors++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        took        = 1'b1;
        idle_cycles = 0;
        seen.seq    = seq_number_i;
        seen.ack    = ack_number_i;
        seen.syn    = syn_flag_i;
        seen.ackf   = ack_flag_i;
        seen.endf   = end_flag_i;
        verdict_q.insert(verdict_q.size(), classify_packet(seen));
        taken_items++;
      end
      if (!took && valid_o !== 1'b1) idle_cycles++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [31:0] key;
    int unsigned r;
    int unsigned idx;
    bit          small_done;
    bit          big_done;
    syn_seen       = '0;
    matched_seen   = '0;
    unmatched_seen = '0;
    small_done     = 1'b0;
    big_done       = 1'b0;

    // directed: key zero hashes to zero, so all eight positions coincide
    queue_packet(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    queue_packet(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    queue_packet(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 1'b0);
    queue_packet(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, 1'b1);
    queue_packet(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 1'b0);
    // all-ones sequence, answered by ack zero (key wraps to all ones)
    queue_packet(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b1);
    queue_packet(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
    queue_packet(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
    // key 2^32-3 shares its hash with key zero
    queue_packet(32'hFFFF_FFFD, 32'h1234_5678, 1'b1, 1'b0, 1'b0);
    queue_packet(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, 1'b0);
    // plain ack and packets with no flags at the field extremes
    queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
    queue_packet(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
    queue_packet(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
    queue_packet(32'h1234_5678, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    queue_packet(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    queue_packet(32'hAAAA_5555, 32'h1234_5679, 1'b1, 1'b1, 1'b1);
    // small key: hash below every prime, positions coincide
    queue_packet(32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    queue_packet(32'h5555_AAAA, 32'h0000_0002, 1'b1, 1'b1, 1'b0);

    // wait for the whole directed part to drain once
    drain_next = 1'b1;
    while (packet_q.size() < N_ITEMS) begin
      if ($urandom_range(0, 149) == 0) drain_next = 1'b1;
      if (!small_done && packet_q.size() >= 300) begin
        // coinciding positions: saturate at the top, then drain through the floor
        small_done = 1'b1;
        key = $urandom_range(0, 400);
        repeat (34) queue_packet(key, $urandom, 1'b1, 1'b0, $urandom_range(0, 7) == 0);
        repeat (35) queue_packet($urandom, key + 32'd1, 1'b1, 1'b1,
                                 $urandom_range(0, 7) == 0);
      end else if (!big_done && packet_q.size() >= 800) begin
        // spread positions: saturate every counter of one full-range key
        big_done = 1'b1;
        key = $urandom;
        repeat (258) queue_packet(key, $urandom, 1'b1, 1'b0, $urandom_range(0, 7) == 0);
        repeat (260) queue_packet($urandom, key + 32'd1, 1'b1, 1'b1,
                                  $urandom_range(0, 7) == 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35 || syn_pool.size() == 0) begin
          key = $urandom;
          syn_pool.insert(syn_pool.size(), key);
          if (syn_pool.size() > 48) syn_pool.delete(0);
          queue_packet(key, $urandom, 1'b1, 1'b0, $urandom_range(0, 7) == 0);
        end else if (r < 65) begin
          // reply to a recent syn
          idx = $urandom_range(0, syn_pool.size() - 1);
          key = syn_pool[idx];
          if ($urandom_range(0, 1) == 0) syn_pool.delete(idx);
          queue_packet($urandom, key + 32'd1, 1'b1, 1'b1, $urandom_range(0, 7) == 0);
        end else if (r < 72) begin
          idx = $urandom_range(0, syn_pool.size() - 1);
          queue_packet(syn_pool[idx], $urandom, 1'b1, 1'b0, $urandom_range(0, 7) == 0);
        end else if (r < 80) begin
          queue_packet($urandom, $urandom, 1'b1, 1'b1, $urandom_range(0, 7) == 0);
        end else begin
          queue_packet($urandom, $urandom, 1'b0, 1'($urandom_range(0, 1)),
                       $urandom_range(0, 7) == 0);
        end
      end
    end
    total_items = packet_q.size();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    wait (taken_items == total_items && verdict_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sbc_pkg.sv
hdl/sbc_ram.sv
hdl/syn_ack_counting_bloom_classifier_top.sv
sim/tb.sv
